// ===== rtl/idm_pkg.sv =====
// ----------------------------------------------------------------------------
// idm_pkg: shared types and constants for the car-following accel pipeline
// register indexes, fixed-point limits and the stage payload structs
// ----------------------------------------------------------------------------
package idm_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMFORT_DECEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DESIRED_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_EXPONENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_HEADWAY   = 3'd5;

  localparam int unsigned MAX_EXPONENT_DEF = 8;

  // width of floor(sqrt(a*b)) for 14-bit a and b
  localparam int unsigned SQRT_W = 14;

  localparam logic [31:0] TERM_MAX = 32'hFFFF_FFFF;
  localparam logic [39:0] GAP_CAP  = 40'hFF_FFFF_FFFF;

  // item context after the multiply stage
  typedef struct packed {
    logic [15:0] v;
    logic        front_use;
    logic [23:0] front_gap;
    logic        rear_use;
    logic        rear_neg;
    logic [23:0] rear_gap;
    logic [23:0] tv_scaled;
    logic [31:0] front_num;
    logic [31:0] rear_num;
  } idm_ctx_t;

  // context riding along the front dynamic-gap divider
  typedef struct packed {
    logic        front_use;
    logic [23:0] front_gap;
    logic        rear_use;
    logic        rear_neg;
    logic [23:0] rear_gap;
    logic [23:0] tv_scaled;
    logic        front_num_zero;
    logic        sqrt_zero;
  } idm_mid_t;

  typedef struct packed {
    logic        front_use;
    logic        sat;
    logic        flag;
    logic        free_en;
    logic [31:0] ratio;
  } idm_front_pl_t;

  typedef struct packed {
    logic rear_use;
    logic sat;
  } idm_rear_pl_t;

endpackage

// ===== rtl/idm_div_pipe.sv =====
// ----------------------------------------------------------------------------
// idm_div_pipe: pipelined restoring divider
// one quotient bit per stage, remainder seeded by the caller, payload rides along
// ----------------------------------------------------------------------------
module idm_div_pipe #(
  parameter int unsigned QW = 32,
  parameter int unsigned DW = 24,
  parameter int unsigned PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_in,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] num_in,
  input  logic [DW-1:0] div_in,
  input  logic [PW-1:0] pl_in,
  output logic          vld_out,
  output logic [QW-1:0] quo_out,
  output logic [PW-1:0] pl_out
);

  logic          vld [0:QW];
  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] nq  [0:QW];
  logic [DW-1:0] dv  [0:QW];
  logic [PW-1:0] pl  [0:QW];

  assign vld[0] = vld_in;
  assign rem[0] = rem_in;
  assign nq[0]  = num_in;
  assign dv[0]  = div_in;
  assign pl[0]  = pl_in;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic        take;

    always_comb begin
      trial = {rem[k], nq[k][QW-1]};
      take  = (trial >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1] <= take ? DW'(trial - {1'b0, dv[k]}) : trial[DW-1:0];
      nq[k+1]  <= {nq[k][QW-2:0], take};
      dv[k+1]  <= dv[k];
      pl[k+1]  <= pl[k];
    end
  end

  assign vld_out = vld[QW];
  assign quo_out = nq[QW];
  assign pl_out  = pl[QW];

endmodule

// ===== rtl/idm_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// idm_sqrt_pipe: pipelined integer square root
// one root bit per stage (digit-by-digit), floor result, payload rides along
// ----------------------------------------------------------------------------
module idm_sqrt_pipe #(
  parameter int unsigned RW = 14,
  parameter int unsigned PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            vld_in,
  input  logic [2*RW-1:0] x_in,
  input  logic [PW-1:0]   pl_in,
  output logic            vld_out,
  output logic [RW-1:0]   root_out,
  output logic [PW-1:0]   pl_out
);

  logic            vld  [0:RW];
  logic [2*RW-1:0] xs   [0:RW];
  logic [RW+1:0]   rem  [0:RW];
  logic [RW-1:0]   root [0:RW];
  logic [PW-1:0]   pl   [0:RW];

  assign vld[0]  = vld_in;
  assign xs[0]   = x_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign pl[0]   = pl_in;

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic          take;
    logic [RW:0]   root_n;

    always_comb begin
      cur    = {rem[k], xs[k][2*RW-1 -: 2]};
      trial  = {2'b00, root[k], 2'b01};
      take   = (cur >= trial);
      root_n = {root[k], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1]  <= take ? (RW+2)'(cur - trial) : cur[RW+1:0];
      root[k+1] <= root_n[RW-1:0];
      xs[k+1]   <= {xs[k][2*RW-3:0], 2'b00};
      pl[k+1]   <= pl[k];
    end
  end

  assign vld_out  = vld[RW];
  assign root_out = root[RW];
  assign pl_out   = pl[RW];

endmodule

// ===== rtl/idm_combine.sv =====
// ----------------------------------------------------------------------------
// idm_combine: term squaring, free-road power chain and final scaling
// one multiply per power-chain stage, result registered on the output ports
// ----------------------------------------------------------------------------
module idm_combine #(
  parameter int unsigned MAX_EXPONENT = idm_pkg::MAX_EXPONENT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  vld_in,
  input  logic [31:0]           quo_front,
  input  logic [31:0]           quo_rear,
  input  idm_pkg::idm_front_pl_t front_pl,
  input  idm_pkg::idm_rear_pl_t  rear_pl,
  input  logic [13:0]           max_accel,
  input  logic [3:0]            speed_exponent,
  output logic                  done,
  output logic signed [31:0]    accel_out,
  output logic [31:0]           free_term,
  output logic [31:0]           front_term,
  output logic [31:0]           rear_term,
  output logic                  zero_gap_flag
);

  import idm_pkg::*;

  localparam int unsigned EXP_W = 5;
  localparam int unsigned LAST  = MAX_EXPONENT - 1;

  function automatic logic [31:0] sat_q16(input logic [63:0] prod);
    sat_q16 = (prod[63:48] != '0) ? TERM_MAX : prod[47:16];
  endfunction

  // clamped exponent
  logic [EXP_W-1:0] exp_eff;
  always_comb begin
    if (speed_exponent == '0) begin
      exp_eff = EXP_W'(1);
    end else if ({1'b0, speed_exponent} > EXP_W'(MAX_EXPONENT)) begin
      exp_eff = EXP_W'(MAX_EXPONENT);
    end else begin
      exp_eff = {1'b0, speed_exponent};
    end
  end

  logic [63:0] sq_f;
  logic [63:0] sq_r;
  assign sq_f = {32'b0, quo_front} * {32'b0, quo_front};
  assign sq_r = {32'b0, quo_rear} * {32'b0, quo_rear};

  logic        pv [0:LAST];
  logic [31:0] pw [0:LAST];
  logic [31:0] rr [0:LAST];
  logic [31:0] tf [0:LAST];
  logic [31:0] tr [0:LAST];
  logic        fl [0:LAST];

  // squaring stage, also seeds the power chain
  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else begin
      pv[0] <= vld_in;
    end
    if (!front_pl.front_use) begin
      tf[0] <= '0;
    end else if (front_pl.sat) begin
      tf[0] <= TERM_MAX;
    end else begin
      tf[0] <= sat_q16(sq_f);
    end
    if (!rear_pl.rear_use) begin
      tr[0] <= '0;
    end else if (rear_pl.sat) begin
      tr[0] <= TERM_MAX;
    end else begin
      tr[0] <= sat_q16(sq_r);
    end
    pw[0] <= front_pl.free_en ? front_pl.ratio : '0;
    rr[0] <= front_pl.ratio;
    fl[0] <= front_pl.flag;
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_pow
    logic [63:0] prod;
    assign prod = {32'b0, pw[k-1]} * {32'b0, rr[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k] <= 1'b0;
      end else begin
        pv[k] <= pv[k-1];
      end
      pw[k] <= (EXP_W'(k) < exp_eff) ? sat_q16(prod) : pw[k-1];
      rr[k] <= rr[k-1];
      tf[k] <= tf[k-1];
      tr[k] <= tr[k-1];
      fl[k] <= fl[k-1];
    end
  end

  // 65536 - free - front + rear
  logic               s_vld;
  logic signed [34:0] s_sum;
  logic [31:0]        s_t1;
  logic [31:0]        s_t2;
  logic [31:0]        s_t3;
  logic               s_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= pv[LAST];
    end
    s_sum <= 35'sd65536 - $signed({3'b000, pw[LAST]}) - $signed({3'b000, tf[LAST]})
             + $signed({3'b000, tr[LAST]});
    s_t1  <= pw[LAST];
    s_t2  <= tf[LAST];
    s_t3  <= tr[LAST];
    s_fl  <= fl[LAST];
  end

  // scale by a
  logic               m_vld;
  logic signed [49:0] m_prod;
  logic [31:0]        m_t1;
  logic [31:0]        m_t2;
  logic [31:0]        m_t3;
  logic               m_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= s_vld;
    end
    m_prod <= s_sum * $signed({1'b0, max_accel});
    m_t1   <= s_t1;
    m_t2   <= s_t2;
    m_t3   <= s_t3;
    m_fl   <= s_fl;
  end

  // floor shift and saturate
  logic [33:0] shifted;
  logic        fits;
  assign shifted = m_prod[49:16];
  assign fits    = (shifted[33:31] == 3'b000) || (shifted[33:31] == 3'b111);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
    if (fits) begin
      accel_out <= $signed(shifted[31:0]);
    end else if (shifted[33]) begin
      accel_out <= 32'sh8000_0000;
    end else begin
      accel_out <= 32'sh7FFF_FFFF;
    end
    free_term     <= m_t1;
    front_term    <= m_t2;
    rear_term     <= m_t3;
    zero_gap_flag <= m_fl;
  end

endmodule

// ===== rtl/idm_car_following_accel.sv =====
// ----------------------------------------------------------------------------
// idm_car_following_accel: intelligent driver model acceleration pipeline
// throughput: one item per cycle, busy is low whenever rst is low
// the pipeline length is set by the bit-per-stage sqrt and the two chained divider pipes
// rst clears all valid bits and loads the register reset values; payload is not reset
// results are strobed on done for one cycle, the receiver cannot stall
// ----------------------------------------------------------------------------
module idm_car_following_accel #(
  parameter int unsigned MAX_EXPONENT = idm_pkg::MAX_EXPONENT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [idm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [idm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [15:0]                     own_speed,
  input  logic                            front_present,
  input  logic [23:0]                     front_gap,
  input  logic [15:0]                     front_speed,
  input  logic                            rear_present,
  input  logic [23:0]                     rear_gap,
  input  logic [15:0]                     rear_speed,
  output logic                            done,
  output logic signed [31:0]              accel_out,
  output logic [31:0]                     free_term,
  output logic [31:0]                     front_term,
  output logic [31:0]                     rear_term,
  output logic                            zero_gap_flag
);

  import idm_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [13:0] max_accel;
  logic [13:0] comfort_decel;
  logic [15:0] desired_speed;
  logic [3:0]  speed_exponent;
  logic [23:0] min_gap;
  logic [15:0] time_headway;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel      <= 14'd1024;
      comfort_decel  <= 14'd2048;
      desired_speed  <= 16'd7680;
      speed_exponent <= 4'd4;
      min_gap        <= 24'd512;
      time_headway   <= 16'd384;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ACCEL:      max_accel      <= cfg_data[13:0];
        REG_COMFORT_DECEL:  comfort_decel  <= cfg_data[13:0];
        REG_DESIRED_SPEED:  desired_speed  <= cfg_data[15:0];
        REG_SPEED_EXPONENT: speed_exponent <= cfg_data[3:0];
        REG_MIN_GAP:        min_gap        <= cfg_data[23:0];
        REG_TIME_HEADWAY:   time_headway   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // the pipeline never stalls, only reset holds off a transfer
  assign busy = rst;

  // --------------------------------------------------------------------------
  // stage a: input register
  // --------------------------------------------------------------------------
  logic        a_vld;
  logic [15:0] a_v;
  logic        a_fp;
  logic [23:0] a_fgap;
  logic [15:0] a_fspd;
  logic        a_rp;
  logic [23:0] a_rgap;
  logic [15:0] a_rspd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
    a_v    <= own_speed;
    a_fp   <= front_present;
    a_fgap <= front_gap;
    a_fspd <= front_speed;
    a_rp   <= rear_present;
    a_rgap <= rear_gap;
    a_rspd <= rear_speed;
  end

  // --------------------------------------------------------------------------
  // stage b: relative speeds and the parallel multiplies
  // front lane only counts when closing in; rear lane keeps the sign of dv
  // --------------------------------------------------------------------------
  logic        a_front_use;
  logic [15:0] a_dvf;
  logic        a_rneg;
  logic [15:0] a_dvr;
  logic [31:0] a_tv;

  always_comb begin
    a_front_use = a_fp && (a_v > a_fspd);
    a_dvf       = a_v - a_fspd;
    a_rneg      = (a_rspd < a_v);
    a_dvr       = a_rneg ? (a_v - a_rspd) : (a_rspd - a_v);
    a_tv        = {16'b0, time_headway} * {16'b0, a_v};
  end

  logic        b_vld;
  idm_ctx_t    b_ctx;
  logic [27:0] b_ab;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_ctx.v         <= a_v;
    b_ctx.front_use <= a_front_use;
    b_ctx.front_gap <= a_fgap;
    b_ctx.rear_use  <= a_rp;
    b_ctx.rear_neg  <= a_rneg;
    b_ctx.rear_gap  <= a_rgap;
    b_ctx.tv_scaled <= a_tv[31:8];
    b_ctx.front_num <= {16'b0, a_v} * {16'b0, a_dvf};
    b_ctx.rear_num  <= {16'b0, a_v} * {16'b0, a_dvr};
    b_ab            <= {14'b0, max_accel} * {14'b0, comfort_decel};
  end

  // --------------------------------------------------------------------------
  // sqrt(a*b), item context carried through
  // --------------------------------------------------------------------------
  logic              q_vld;
  logic [SQRT_W-1:0] q_sqrt;
  logic [$bits(idm_ctx_t)-1:0] q_ctx_bits;
  idm_ctx_t          q_ctx;

  idm_sqrt_pipe #(
    .RW (SQRT_W),
    .PW ($bits(idm_ctx_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (b_vld),
    .x_in     (b_ab),
    .pl_in    (b_ctx),
    .vld_out  (q_vld),
    .root_out (q_sqrt),
    .pl_out   (q_ctx_bits)
  );

  assign q_ctx = q_ctx_bits;

  // --------------------------------------------------------------------------
  // dynamic gap 2*v*|dv|/sqrt(a*b) for both lanes, and v/v0 for the free term
  // the three dividers run in lockstep
  // --------------------------------------------------------------------------
  idm_mid_t q_mid;
  always_comb begin
    q_mid.front_use      = q_ctx.front_use;
    q_mid.front_gap      = q_ctx.front_gap;
    q_mid.rear_use       = q_ctx.rear_use;
    q_mid.rear_neg       = q_ctx.rear_neg;
    q_mid.rear_gap       = q_ctx.rear_gap;
    q_mid.tv_scaled      = q_ctx.tv_scaled;
    q_mid.front_num_zero = (q_ctx.front_num == '0);
    q_mid.sqrt_zero      = (q_sqrt == '0);
  end

  logic                      df_vld;
  logic [32:0]               df_quo;
  logic [$bits(idm_mid_t)-1:0] df_pl;
  idm_mid_t                  df_mid;
  logic                      dr_vld;
  logic [32:0]               dr_quo;
  logic                      dr_num_zero;
  logic                      dw_vld;
  logic [32:0]               dw_quo;
  logic                      dw_free_en;

  idm_div_pipe #(
    .QW (33),
    .DW (SQRT_W),
    .PW ($bits(idm_mid_t))
  ) u_div_dyn_front (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (q_vld),
    .rem_in  ('0),
    .num_in  ({q_ctx.front_num, 1'b0}),
    .div_in  (q_sqrt),
    .pl_in   (q_mid),
    .vld_out (df_vld),
    .quo_out (df_quo),
    .pl_out  (df_pl)
  );

  assign df_mid = df_pl;

  idm_div_pipe #(
    .QW (33),
    .DW (SQRT_W),
    .PW (1)
  ) u_div_dyn_rear (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (q_vld),
    .rem_in  ('0),
    .num_in  ({q_ctx.rear_num, 1'b0}),
    .div_in  (q_sqrt),
    .pl_in   (q_ctx.rear_num == '0),
    .vld_out (dr_vld),
    .quo_out (dr_quo),
    .pl_out  (dr_num_zero)
  );

  idm_div_pipe #(
    .QW (33),
    .DW (16),
    .PW (1)
  ) u_div_free (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (q_vld),
    .rem_in  ('0),
    .num_in  ({1'b0, q_ctx.v, 16'h0000}),
    .div_in  (desired_speed),
    .pl_in   (desired_speed != '0),
    .vld_out (dw_vld),
    .quo_out (dw_quo),
    .pl_out  (dw_free_en)
  );

  // --------------------------------------------------------------------------
  // stage d: desired gap s* = s0 + T*v +/- dyn, capped at 40 bits
  // zero numerator gives no dynamic part, zero sqrt with nonzero numerator caps it
  // --------------------------------------------------------------------------
  logic [39:0] dyn_f;
  logic [39:0] dyn_r;
  logic [39:0] base;
  logic [40:0] sum_f;
  logic [40:0] sum_r;
  logic [39:0] s_front;
  logic [39:0] s_rear;

  always_comb begin
    if (df_mid.front_num_zero) begin
      dyn_f = '0;
    end else if (df_mid.sqrt_zero) begin
      dyn_f = GAP_CAP;
    end else begin
      dyn_f = {7'b0, df_quo};
    end
    if (dr_num_zero) begin
      dyn_r = '0;
    end else if (df_mid.sqrt_zero) begin
      dyn_r = GAP_CAP;
    end else begin
      dyn_r = {7'b0, dr_quo};
    end
    base    = {16'b0, min_gap} + {16'b0, df_mid.tv_scaled};
    sum_f   = {1'b0, dyn_f} + {1'b0, base};
    sum_r   = {1'b0, dyn_r} + {1'b0, base};
    s_front = sum_f[40] ? GAP_CAP : sum_f[39:0];
    if (!df_mid.rear_neg) begin
      s_rear = sum_r[40] ? GAP_CAP : sum_r[39:0];
    end else if (dyn_r > base) begin
      s_rear = dyn_r - base;
    end else begin
      s_rear = base - dyn_r;
    end
  end

  logic        d_vld;
  logic [39:0] d_sf;
  logic [39:0] d_sr;
  logic [23:0] d_fgap;
  logic [23:0] d_rgap;
  logic        d_front_use;
  logic        d_rear_use;
  logic        d_flag;
  logic        d_free_en;
  logic [31:0] d_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= df_vld && dr_vld && dw_vld;
    end
    d_sf        <= s_front;
    d_sr        <= s_rear;
    d_fgap      <= df_mid.front_gap;
    d_rgap      <= df_mid.rear_gap;
    d_front_use <= df_mid.front_use;
    d_rear_use  <= df_mid.rear_use;
    d_flag      <= (df_mid.front_use && (df_mid.front_gap == '0)) ||
                   (df_mid.rear_use && (df_mid.rear_gap == '0));
    d_free_en   <= dw_free_en;
    d_ratio     <= dw_quo[31:0];
  end

  // --------------------------------------------------------------------------
  // ratio (s<<16)/gap: when the upper part already reaches the gap the quotient
  // overflows 32 bits and saturates (zero gap lands here too); otherwise the
  // upper part seeds the remainder and 32 bits are left to divide
  // --------------------------------------------------------------------------
  logic          sat_f;
  logic          sat_r;
  idm_front_pl_t rf_pl_in;
  idm_rear_pl_t  rr_pl_in;

  always_comb begin
    sat_f              = (d_sf[39:16] >= d_fgap);
    sat_r              = (d_sr[39:16] >= d_rgap);
    rf_pl_in.front_use = d_front_use;
    rf_pl_in.sat       = sat_f;
    rf_pl_in.flag      = d_flag;
    rf_pl_in.free_en   = d_free_en;
    rf_pl_in.ratio     = d_ratio;
    rr_pl_in.rear_use  = d_rear_use;
    rr_pl_in.sat       = sat_r;
  end

  logic                           rf_vld;
  logic [31:0]                    rf_quo;
  logic [$bits(idm_front_pl_t)-1:0] rf_pl;
  logic                           rr_vld;
  logic [31:0]                    rr_quo;
  logic [$bits(idm_rear_pl_t)-1:0]  rr_pl;

  idm_div_pipe #(
    .QW (32),
    .DW (24),
    .PW ($bits(idm_front_pl_t))
  ) u_div_ratio_front (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (d_vld),
    .rem_in  (sat_f ? 24'h000000 : d_sf[39:16]),
    .num_in  ({d_sf[15:0], 16'h0000}),
    .div_in  (d_fgap),
    .pl_in   (rf_pl_in),
    .vld_out (rf_vld),
    .quo_out (rf_quo),
    .pl_out  (rf_pl)
  );

  idm_div_pipe #(
    .QW (32),
    .DW (24),
    .PW ($bits(idm_rear_pl_t))
  ) u_div_ratio_rear (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (d_vld),
    .rem_in  (sat_r ? 24'h000000 : d_sr[39:16]),
    .num_in  ({d_sr[15:0], 16'h0000}),
    .div_in  (d_rgap),
    .pl_in   (rr_pl_in),
    .vld_out (rr_vld),
    .quo_out (rr_quo),
    .pl_out  (rr_pl)
  );

  // --------------------------------------------------------------------------
  // squaring, free-road power, final a*(...) and output register
  // --------------------------------------------------------------------------
  idm_combine #(
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_combine (
    .clk            (clk),
    .rst            (rst),
    .vld_in         (rf_vld && rr_vld),
    .quo_front      (rf_quo),
    .quo_rear       (rr_quo),
    .front_pl       (idm_front_pl_t'(rf_pl)),
    .rear_pl        (idm_rear_pl_t'(rr_pl)),
    .max_accel      (max_accel),
    .speed_exponent (speed_exponent),
    .done           (done),
    .accel_out      (accel_out),
    .free_term      (free_term),
    .front_term     (front_term),
    .rear_term      (rear_term),
    .zero_gap_flag  (zero_gap_flag)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_reset_clears_done: assert property (@(posedge clk) rst |=> !done)
    else $error("done strobe survived reset");

  a_flag_saturates: assert property (@(posedge clk) disable iff (rst)
    (done && zero_gap_flag) |-> ((front_term == TERM_MAX) || (rear_term == TERM_MAX)))
    else $error("zero gap flag without a saturated term");

  a_closing_nonzero: assert property (@(posedge clk) disable iff (rst)
    (b_vld && b_ctx.front_use) |-> (b_ctx.front_num != '0))
    else $error("closing front vehicle gave zero v*dv");

endmodule
